// ----- rtl/htw_pkg.sv -----
// Package with shared types and constants for the timer wheel.
package htw_pkg;

  localparam int TIMERS_DEF = 16;
  localparam int LEVELS_DEF = 5;
  localparam int SLOTS_DEF = 64;
  localparam int LEVEL_SHIFT_STEP_DEF = 3;
  localparam int MAXTO_W = 18;
  localparam logic [MAXTO_W-1:0] MAXTO_RESET = 18'h3FFFF;
  localparam int QDEPTH = 2;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] timer_id;
    logic [31:0] delay;
  } in_item_t;

  typedef struct packed {
    logic status;
    logic was_armed;
    logic fired_valid;
    logic [3:0] fired_id;
    logic last;
    logic [63:0] clock_now;
  } out_item_t;

  // Classified command from the front end to the back end.
  typedef struct packed {
    logic [1:0] func;
    logic [3:0] timer_id;
    logic id_ok;
    logic reject;
    logic [31:0] delta;
  } cmd_t;

endpackage

// ----- rtl/htw_front.sv -----
// Front end: accepts commands, classifies them and queues them for the back end.
module htw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  htw_pkg::in_item_t              in_data,
  input  logic [htw_pkg::MAXTO_W-1:0]    max_timeout,
  input  logic [6:0]                     timers,
  output logic                           q_valid,
  input  logic                           q_pop,
  output htw_pkg::cmd_t                  q_data
);

  htw_pkg::cmd_t q_mem_r [htw_pkg::QDEPTH];
  logic q_wp_r, q_wp_nxt, q_rp_r, q_rp_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  htw_pkg::cmd_t cmd;
  logic [31:0] d;
  logic push;

  always_comb begin
    d = (in_data.delay == 32'd0) ? 32'd1 : in_data.delay;
    cmd.func = in_data.func;
    cmd.timer_id = in_data.timer_id;
    cmd.id_ok = ({3'd0, in_data.timer_id} < timers);
    cmd.delta = d;
    cmd.reject = !cmd.id_ok || (d > {14'd0, max_timeout});
  end

  assign in_stall = (q_cnt_r == 2'(htw_pkg::QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data = q_mem_r[q_rp_r];

  always_comb begin
    q_wp_nxt = q_wp_r + 1'b1;
    q_rp_nxt = q_rp_r + 1'b1;
    q_cnt_nxt = q_cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= q_wp_nxt;
      if (q_pop && q_valid) q_rp_r <= q_rp_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wp_r] <= cmd;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'(htw_pkg::QDEPTH)) else $error("queue overflow");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_valid) else $error("stall while empty");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd0) |=> (q_cnt_r <= 2'd1)) else $error("queue jumped");
`endif

endmodule

// ----- rtl/htw_back.sv -----
// Back end: timer slot state, command execution and the tick scan sequencer.
module htw_back #(
  parameter int TIMERS = htw_pkg::TIMERS_DEF,
  parameter int LEVELS = htw_pkg::LEVELS_DEF,
  parameter int SLOTS = htw_pkg::SLOTS_DEF,
  parameter int LEVEL_SHIFT_STEP = htw_pkg::LEVEL_SHIFT_STEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  htw_pkg::cmd_t      q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output htw_pkg::out_item_t out_data
);

  localparam int TW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(TIMERS + 1);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW = $clog2(SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EMIT = 3'd2;
  localparam logic [2:0] ST_SEND = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [63:0] clk_r, clk_nxt;
  logic [TIMERS-1:0] armed_r, armed_nxt;
  logic [LW-1:0] lvl_r [TIMERS];
  logic [LW-1:0] lvl_nxt [TIMERS];
  logic [SW-1:0] bkt_r [TIMERS];
  logic [SW-1:0] bkt_nxt [TIMERS];
  logic [TW-1:0] rank_r [TIMERS];
  logic [TW-1:0] rank_nxt [TIMERS];
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Scan position: level and rank in nested order.
  logic [LW-1:0] sl_r, sl_nxt;
  logic [CW-1:0] sr_r, sr_nxt;

  // Fired slots in firing order, as found by the scan.
  logic [TW-1:0] fire_r [TIMERS];
  logic [TW-1:0] fire_nxt [TIMERS];
  logic [CW-1:0] nf_r, nf_nxt;
  logic [CW-1:0] ef_r, ef_nxt;
  logic [TW-1:0] fid_r, fid_nxt;

  // Output register.
  htw_pkg::out_item_t ob_r, ob_nxt;
  logic ov_r, ov_nxt;

  logic [63:0] clk_inc;
  logic lvl_active;
  logic lvl_done;
  logic [SW-1:0] cur_bkt;
  logic [TIMERS-1:0] hit;
  logic [TW-1:0] hit_id;
  logic hit_any;
  logic ob_free;

  // Add computation.
  logic [LW-1:0] add_lvl;
  logic [63:0] exp_raw, exp_rnd;
  logic [SW-1:0] add_bkt;
  logic [TW-1:0] cid;

  assign ob_free = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data = ob_r;
  assign cid = TW'(q_data.timer_id);
  assign clk_inc = clk_r + 64'd1;

  always_comb begin
    add_lvl = LW'(LEVELS - 1);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if ({32'd0, q_data.delta} < (64'(SLOTS) << (i * LEVEL_SHIFT_STEP))) add_lvl = LW'(i);
    end
    exp_raw = clk_r + {32'd0, q_data.delta};
    exp_rnd = (exp_raw + ((64'd1 << (add_lvl * LEVEL_SHIFT_STEP)) - 64'd1))
              >> (add_lvl * LEVEL_SHIFT_STEP);
    add_bkt = exp_rnd[SW-1:0];
  end

  always_comb begin
    lvl_active = (sl_r == '0) ||
      ((clk_r & ((64'd1 << (sl_r * LEVEL_SHIFT_STEP)) - 64'd1)) == 64'd0);
    cur_bkt = SW'(clk_r >> (sl_r * LEVEL_SHIFT_STEP));
    hit = '0;
    for (int i = 0; i < TIMERS; i++) begin
      hit[i] = armed_r[i] && (lvl_r[i] == sl_r) && (bkt_r[i] == cur_bkt) &&
               (CW'(rank_r[i]) == sr_r);
    end
    hit_any = |hit;
    hit_id = '0;
    for (int i = 0; i < TIMERS; i++) if (hit[i]) hit_id = TW'(i);
    lvl_done = (sr_r + CW'(1) >= cnt_r) || !lvl_active;
  end

  assign q_pop = (st_r == ST_IDLE) && q_valid && ob_free;

  always_comb begin
    st_nxt = st_r;
    clk_nxt = clk_r;
    armed_nxt = armed_r;
    lvl_nxt = lvl_r;
    bkt_nxt = bkt_r;
    rank_nxt = rank_r;
    cnt_nxt = cnt_r;
    sl_nxt = sl_r;
    sr_nxt = sr_r;
    fire_nxt = fire_r;
    nf_nxt = nf_r;
    ef_nxt = ef_r;
    fid_nxt = fid_r;
    ob_nxt = ob_r;
    ov_nxt = ov_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        if (q_pop) begin
          ov_nxt = (q_data.func != htw_pkg::FUNC_TICK);
          ob_nxt = '0;
          ob_nxt.last = 1'b1;
          ob_nxt.clock_now = clk_r;
          case (q_data.func)
            htw_pkg::FUNC_ADD: begin
              if (q_data.reject) ob_nxt.status = 1'b1;
              else begin
                // Remove then append as newest.
                for (int i = 0; i < TIMERS; i++)
                  if (armed_r[cid] && armed_r[i] && rank_r[i] > rank_r[cid])
                    rank_nxt[i] = rank_r[i] - TW'(1);
                lvl_nxt[cid] = add_lvl;
                bkt_nxt[cid] = add_bkt;
                rank_nxt[cid] = TW'(cnt_r - CW'(armed_r[cid]));
                cnt_nxt = cnt_r - CW'(armed_r[cid]) + CW'(1);
                armed_nxt[cid] = 1'b1;
              end
            end
            htw_pkg::FUNC_CANCEL: begin
              if (q_data.id_ok && armed_r[cid]) begin
                ob_nxt.was_armed = 1'b1;
                for (int i = 0; i < TIMERS; i++)
                  if (armed_r[i] && rank_r[i] > rank_r[cid])
                    rank_nxt[i] = rank_r[i] - TW'(1);
                armed_nxt[cid] = 1'b0;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            htw_pkg::FUNC_TICK: begin
              clk_nxt = clk_inc;
              ob_nxt.clock_now = clk_inc;
              sl_nxt = '0;
              sr_nxt = '0;
              nf_nxt = '0;
              ef_nxt = '0;
              st_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // One rank of one level per cycle; hits are found in firing order.
        if (lvl_active && hit_any) begin
          fire_nxt[nf_r[TW-1:0]] = hit_id;
          nf_nxt = nf_r + CW'(1);
        end
        if (lvl_done) begin
          sr_nxt = '0;
          if (sl_r != LW'(LEVELS - 1)) sl_nxt = sl_r + LW'(1);
          else st_nxt = ST_EMIT;
        end else begin
          sr_nxt = sr_r + CW'(1);
        end
      end
      ST_EMIT: begin
        if (ob_free) begin
          if (ef_r == nf_r) begin
            st_nxt = ST_IDLE;
            if (nf_r == '0) begin
              ov_nxt = 1'b1;
              ob_nxt.fired_valid = 1'b0;
              ob_nxt.fired_id = '0;
              ob_nxt.last = 1'b1;
            end
          end else begin
            fid_nxt = fire_r[ef_r[TW-1:0]];
            ef_nxt = ef_r + CW'(1);
            st_nxt = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        // Fire the next slot in order and disarm it.
        ov_nxt = 1'b1;
        ob_nxt.fired_valid = 1'b1;
        ob_nxt.fired_id = 4'(fid_r);
        ob_nxt.last = (ef_r == nf_r);
        armed_nxt[fid_r] = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
        for (int i = 0; i < TIMERS; i++)
          if (armed_r[i] && rank_r[i] > rank_r[fid_r]) rank_nxt[i] = rank_r[i] - TW'(1);
        st_nxt = ST_EMIT;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      clk_r <= 64'd0;
      armed_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
      sl_r <= '0;
      sr_r <= '0;
      nf_r <= '0;
      ef_r <= '0;
    end else begin
      st_r <= st_nxt;
      clk_r <= clk_nxt;
      armed_r <= armed_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      sl_r <= sl_nxt;
      sr_r <= sr_nxt;
      nf_r <= nf_nxt;
      ef_r <= ef_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    bkt_r <= bkt_nxt;
    rank_r <= rank_nxt;
    fire_r <= fire_nxt;
    fid_r <= fid_nxt;
    ob_r <= ob_nxt;
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(armed_r))) else $error("armed count mismatch");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ef_r <= nf_r) else $error("emitted more than fired");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE)) else $error("pop while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ob_r))) else $error("stalled result changed");
`endif

endmodule

// ----- rtl/hierarchical_timer_wheel.sv -----
// Top level of the hierarchical timer wheel: config register, front end, back end.
// Add, cancel and unused codes: queued at acceptance, popped once the back end is idle and
// its output is free, result offered the cycle after the pop; up to one command per cycle
// without stalls. A tick is popped, scans each active level rank by rank and passes over
// inactive ones, then emits each fired timer or one empty result; one command at a time.
// Reset (rst_n low, synchronous) clears the clock, armed flags and queue; max_timeout = max.
module hierarchical_timer_wheel #(
  parameter int TIMERS = htw_pkg::TIMERS_DEF,
  parameter int LEVELS = htw_pkg::LEVELS_DEF,
  parameter int SLOTS = htw_pkg::SLOTS_DEF,
  parameter int LEVEL_SHIFT_STEP = htw_pkg::LEVEL_SHIFT_STEP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  htw_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output htw_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [htw_pkg::MAXTO_W-1:0]  cfg_data
);

  logic [htw_pkg::MAXTO_W-1:0] maxto_r;
  logic q_valid, q_pop;
  htw_pkg::cmd_t q_data;

  // Register always ready; the user must make writes only while the block is idle, unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) maxto_r <= htw_pkg::MAXTO_RESET;
    else if (cfg_valid) maxto_r <= cfg_data;
  end

  htw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .max_timeout(maxto_r), .timers(7'(TIMERS)),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  htw_back #(
    .TIMERS(TIMERS), .LEVELS(LEVELS), .SLOTS(SLOTS), .LEVEL_SHIFT_STEP(LEVEL_SHIFT_STEP)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// ----- bench/hierarchical_timer_wheel_test.sv -----
// Self-checking testbench for the hierarchical timer wheel.
`timescale 1ns / 100ps

module hierarchical_timer_wheel_test;

  // Operation code that the block does not use; it must report a result with no flag but last.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_REJECT = 1'b1;
  localparam int NTIMERS = 16;
  localparam int NLEVELS = 5;
  localparam int SHIFT_STEP = 3;
  localparam int NSLOTS = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 47;
  localparam int DIRECTED_ROWS = 22;

  typedef struct packed {
    htw_pkg::in_item_t cmd;
    logic typed;
    htw_pkg::out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  htw_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  htw_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [htw_pkg::MAXTO_W-1:0] cfg_data;

  hierarchical_timer_wheel DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the wheel, kept in step with every accepted transfer.
  logic [63:0] wheel_clock;
  logic [htw_pkg::MAXTO_W-1:0] timeout_limit;
  logic armed [NTIMERS];
  int unsigned lvl [NTIMERS];
  int unsigned bkt [NTIMERS];
  int unsigned order [NTIMERS];
  int unsigned live_count;

  // Results the block still owes, oldest first.
  htw_pkg::out_item_t pending_results [$];

  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct;
  int stall_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Removes a slot from the armed set and closes the gap in insertion order.
  function automatic void slot_release(int unsigned s);
    if (!armed[s]) return;
    for (int i = 0; i < NTIMERS; i++)
      if (armed[i] && order[i] > order[s]) order[i]--;
    armed[s] = 1'b0;
    live_count--;
  endfunction

  // Works out the results of one accepted command and updates the shadow wheel.
  function automatic void wheel_predict(htw_pkg::in_item_t it);
    htw_pkg::out_item_t r;
    logic [63:0] delta;
    logic [63:0] expiry;
    logic [63:0] gran;
    int unsigned lv;
    int unsigned b;
    int unsigned fired [$];
    r = '0;
    r.last = 1'b1;
    case (it.func)
      htw_pkg::FUNC_ADD: begin
        delta = {32'd0, it.delay};
        if (delta == 64'd0) delta = 64'd1;
        if (delta > {46'd0, timeout_limit}) begin
          r.status = ST_REJECT;
        end else begin
          slot_release(32'(it.timer_id));
          lv = NLEVELS - 1;
          for (int l = NLEVELS - 1; l >= 0; l--)
            if (delta < (64'(NSLOTS) << (l * SHIFT_STEP))) lv = l;
          gran = 64'd1 << (lv * SHIFT_STEP);
          expiry = (wheel_clock + delta + gran - 64'd1) & ~(gran - 64'd1);
          lvl[it.timer_id] = lv;
          bkt[it.timer_id] = 32'((expiry >> (lv * SHIFT_STEP)) & 64'(NSLOTS - 1));
          order[it.timer_id] = live_count;
          armed[it.timer_id] = 1'b1;
          live_count++;
          r.status = ST_OK;
        end
      end
      htw_pkg::FUNC_CANCEL: begin
        if (armed[it.timer_id]) begin
          r.was_armed = 1'b1;
          slot_release(32'(it.timer_id));
        end
      end
      htw_pkg::FUNC_TICK: begin
        wheel_clock = wheel_clock + 64'd1;
        for (int l = 0; l < NLEVELS; l++) begin
          gran = 64'd1 << (l * SHIFT_STEP);
          if (l == 0 || (wheel_clock & (gran - 64'd1)) == 64'd0) begin
            b = 32'((wheel_clock >> (l * SHIFT_STEP)) & 64'(NSLOTS - 1));
            for (int unsigned k = 0; k < live_count; k++)
              for (int i = 0; i < NTIMERS; i++)
                if (armed[i] && order[i] == k && lvl[i] == l && bkt[i] == b)
                  fired.push_back(32'(i));
          end
        end
        foreach (fired[i]) slot_release(fired[i]);
        if (fired.size() > 0) begin
          // One result per expired slot; only the final one carries last.
          foreach (fired[i]) begin
            r = '0;
            r.fired_valid = 1'b1;
            r.fired_id = 4'(fired[i]);
            r.last = (i == fired.size() - 1);
            r.clock_now = wheel_clock;
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.clock_now = wheel_clock;
    pending_results.push_back(r);
  endfunction

  // Offers one command, with random idle cycles ahead of it, and predicts it
  // at the edge where the transfer happens.
  task automatic send_cmd(htw_pkg::in_item_t it, logic typed, htw_pkg::out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    wheel_predict(it);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  // Waits for the block to drain, then writes max_timeout.
  task automatic write_limit(logic [htw_pkg::MAXTO_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    timeout_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command, weighted toward ticks and short delays so that timers
  // actually expire, with some noise: huge deltas, values around the limit
  // and the unused operation code.
  function automatic htw_pkg::in_item_t random_cmd();
    htw_pkg::in_item_t it;
    int pick;
    it.timer_id = 4'($urandom_range(15));
    it.delay = '0;
    pick = $urandom_range(99);
    if (pick < 52) it.func = htw_pkg::FUNC_TICK;
    else if (pick < 82) it.func = htw_pkg::FUNC_ADD;
    else if (pick < 95) it.func = htw_pkg::FUNC_CANCEL;
    else it.func = FUNC_UNUSED;
    pick = $urandom_range(99);
    if (pick < 50) it.delay = $urandom_range(12);
    else if (pick < 70) it.delay = $urandom_range(700);
    else if (pick < 80) it.delay = $urandom_range(5000);
    else if (pick < 90) it.delay = $urandom;
    else it.delay = 32'(timeout_limit) + $urandom_range(2) - 1;
    return it;
  endfunction

  // Receiver: random stalls, or a solid stall while the hold-off is on.
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin
    htw_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status || out_data.was_armed !== exp_r.was_armed ||
            out_data.fired_valid !== exp_r.fired_valid ||
            out_data.fired_id !== exp_r.fired_id || out_data.last !== exp_r.last ||
            out_data.clock_now !== exp_r.clock_now) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_data);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Long receiver hold-off in the last phase; the sender keeps offering, so the
  // input queue fills and the block must stall its input.
  initial begin
    hold_off = 1'b0;
    wait (send_idle_pct == 17);
    repeat (30) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    dir_row_t directed_tab [DIRECTED_ROWS];
    logic [htw_pkg::MAXTO_W-1:0] phase_limit [4];
    int phase_send [4];
    int phase_stall [4];
    htw_pkg::in_item_t it;
    directed_tab = '{
      // Tick straight after reset: nothing armed, clock moves to one.
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      // Cancel of a slot that was never armed.
      '{'{htw_pkg::FUNC_CANCEL, 4'd15, 32'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      // Zero delay is taken as one tick.
      '{'{htw_pkg::FUNC_ADD, 4'd0, 32'd0}, 1'b1,
        '{ST_OK, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      // Largest delta field is rejected.
      '{'{htw_pkg::FUNC_ADD, 4'd15, 32'hFFFFFFFF}, 1'b1,
        '{ST_REJECT, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      // Exactly the limit lands on the outermost level.
      '{'{htw_pkg::FUNC_ADD, 4'd15, 32'd262143}, 1'b1,
        '{ST_OK, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      '{'{htw_pkg::FUNC_ADD, 4'd7, 32'd262144}, 1'b1,
        '{ST_REJECT, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      // Two slots in one bucket, then a re-add that moves slot 3 behind slot 5.
      '{'{htw_pkg::FUNC_ADD, 4'd3, 32'd5}, 1'b0, '0},
      '{'{htw_pkg::FUNC_ADD, 4'd5, 32'd5}, 1'b0, '0},
      '{'{htw_pkg::FUNC_ADD, 4'd3, 32'd5}, 1'b0, '0},
      '{'{FUNC_UNUSED, 4'd9, 32'd77}, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1, 64'd1}},
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b0, '0},
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b0, '0},
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b0, '0},
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b0, '0},
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b0, '0},
      '{'{htw_pkg::FUNC_TICK, 4'd0, 32'd0}, 1'b0, '0},
      // First delay that needs level one, cancelled twice.
      '{'{htw_pkg::FUNC_ADD, 4'd9, 32'd64}, 1'b0, '0},
      '{'{htw_pkg::FUNC_CANCEL, 4'd9, 32'd0}, 1'b1,
        '{1'b0, 1'b1, 1'b0, 4'd0, 1'b1, 64'd7}},
      '{'{htw_pkg::FUNC_CANCEL, 4'd9, 32'd0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 4'd0, 1'b1, 64'd7}},
      '{'{htw_pkg::FUNC_ADD, 4'd10, 32'd100}, 1'b0, '0},
      '{'{htw_pkg::FUNC_CANCEL, 4'd15, 32'd0}, 1'b1,
        '{1'b0, 1'b1, 1'b0, 4'd0, 1'b1, 64'd7}},
      '{'{htw_pkg::FUNC_ADD, 4'd12, 32'd8}, 1'b0, '0}
    };
    // Each phase pairs a limit setting with an idling pattern.
    phase_limit = '{18'd262143, 18'd20, 18'd1, 18'd700};
    phase_send = '{0, 74, 0, 17};
    phase_stall = '{0, 0, 74, 17};

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    wheel_clock = '0;
    timeout_limit = htw_pkg::MAXTO_RESET;
    live_count = 0;
    for (int i = 0; i < NTIMERS; i++) begin
      armed[i] = 1'b0;
      lvl[i] = 0;
      bkt[i] = 0;
      order[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_tab[i])
      send_cmd(directed_tab[i].cmd, directed_tab[i].typed, directed_tab[i].want);

    for (int p = 0; p < 4; p++) begin
      write_limit(phase_limit[p]);
      send_idle_pct = phase_send[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        it = random_cmd();
        send_cmd(it, 1'b0, '0);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0 || hold_off) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/htw_pkg.sv
rtl/htw_front.sv
rtl/htw_back.sv
rtl/hierarchical_timer_wheel.sv
bench/hierarchical_timer_wheel_test.sv
